// ===== src/adaptive_block_float_encoder_macros.svh =====
// assertion macros for the block float encoder
`ifndef ADAPTIVE_BLOCK_FLOAT_ENCODER_MACROS_SVH
`define ADAPTIVE_BLOCK_FLOAT_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clk, rst, cond)
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== src/abfe_pkg.sv =====
// shared types, constants and value decoding for the block float encoder
`timescale 1ns / 1ps
package abfe_pkg;

  localparam int MAX_BLOCK_DEF = 32;
  localparam int CNT_W = 6;
  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;

  typedef enum logic [1:0] {
    REG_BLOCK_LENGTH   = 2'd0,
    REG_EXPONENT_WIDTH = 2'd1,
    REG_OFFSET_WIDTH   = 2'd2,
    REG_MANTISSA_WIDTH = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {VAL_ZERO, VAL_FINITE, VAL_SPECIAL} val_kind_t;

  typedef enum logic [1:0] {MAG_ZERO, MAG_SAT, MAG_CALC} mag_mode_t;

  typedef enum logic [1:0] {B_IDLE, B_HEAD, B_MUL, B_EMIT} back_state_t;

  typedef enum logic {KIND_HEADER, KIND_ELEMENT} item_kind_t;

  typedef struct packed {
    logic [5:0] block_length;
    logic [4:0] exponent_width;
    logic [3:0] offset_width;
    logic [5:0] mantissa_width;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    block_length:   6'd32,
    exponent_width: 5'd8,
    offset_width:   4'd3,
    mantissa_width: 6'd8
  };

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic signed [8:0]  shared;
  } desc_t;

  typedef struct packed {
    val_kind_t          kind;
    logic signed [8:0]  e;
    logic [23:0]        sig;
    logic signed [8:0]  q;
  } val_t;

  // frexp exponent, significand and scale of a raw single
  function automatic val_t split_value(input logic [31:0] b);
    val_t v;
    logic [7:0] ex;
    logic [22:0] fr;
    logic [4:0] len;
    ex = b[30:23];
    fr = b[22:0];
    len = '0;
    for (int i = 0; i < 23; i++) begin
      if (fr[i]) len = 5'(i + 1);
    end
    v.kind = VAL_FINITE;
    v.e = '0;
    v.sig = '0;
    v.q = '0;
    if (ex == '0) begin
      if (fr == '0) begin
        v.kind = VAL_ZERO;
      end else begin
        v.sig = {1'b0, fr};
        v.q = -9'sd149;
        v.e = $signed({4'b0, len}) - 9'sd149;
      end
    end else if (ex == EXP_ALL_ONES) begin
      v.kind = VAL_SPECIAL;
      v.e = 9'sd129;
    end else begin
      v.sig = {1'b1, fr};
      v.q = $signed({1'b0, ex}) - 9'sd150;
      v.e = $signed({1'b0, ex}) - 9'sd126;
    end
    return v;
  endfunction

endpackage

// ===== src/abfe_queue.sv =====
// two-block value buffer with its block descriptor queue
`timescale 1ns / 1ps
module abfe_queue import abfe_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF,
  localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  desc_t            push_desc,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output desc_t            head,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [31:0]      wr_data,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [31:0]      rd_data
);

  localparam int DEPTH = 2 * (2 ** IDX_W);

  desc_t slots [2];
  logic wptr;
  logic rptr;
  logic [1:0] count;
  logic [31:0] mem [DEPTH];

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_desc;
  end

  // each bank holds one block
  always_ff @(posedge clk) begin
    if (wr_en) mem[{wptr, wr_idx}] <= wr_data;
    rd_data <= mem[{rptr, rd_idx}];
  end

endmodule

// ===== src/abfe_front.sv =====
// input side: stores values and tracks the block exponent
`timescale 1ns / 1ps
module abfe_front import abfe_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF,
  localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      in_data,
  input  logic             in_last,
  input  logic [5:0]       block_length,
  input  logic             q_full,
  output logic             push,
  output desc_t            push_desc,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_idx,
  output logic [31:0]      wr_data
);

  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_BLOCK);

  logic [CNT_W-1:0] fill, fill_next;
  logic signed [8:0] max_exp, max_exp_next;
  logic seen, seen_next;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] cnt1;
  val_t v;
  logic take;
  logic nz;
  logic close;
  logic new_seen;
  logic signed [8:0] new_max;

  assign in_ready = !q_full;
  assign take = in_valid && in_ready;

  always_comb begin
    if (block_length == '0) begin
      len = CNT_W'(1);
    end else if (block_length > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = block_length;
    end
  end

  assign v = split_value(in_data);
  assign nz = (v.kind != VAL_ZERO);
  assign new_seen = seen || nz;
  assign new_max = (nz && (!seen || (v.e > max_exp))) ? v.e : max_exp;
  assign cnt1 = fill + CNT_W'(1);
  assign close = in_last || (cnt1 >= len);

  assign push = take && close;
  assign push_desc = '{count: cnt1, shared: (new_seen ? new_max : 9'sd0)};
  assign wr_en = take;
  assign wr_idx = fill[IDX_W-1:0];
  assign wr_data = in_data;

  always_comb begin
    fill_next = fill;
    max_exp_next = max_exp;
    seen_next = seen;
    if (take) begin
      if (close) begin
        fill_next = '0;
        max_exp_next = '0;
        seen_next = 1'b0;
      end else begin
        fill_next = cnt1;
        max_exp_next = new_max;
        seen_next = new_seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      max_exp <= '0;
      seen <= 1'b0;
    end else begin
      fill <= fill_next;
      max_exp <= max_exp_next;
      seen <= seen_next;
    end
  end

endmodule

// ===== src/abfe_back.sv =====
// output side: emits the header and the quantised elements of each block
`timescale 1ns / 1ps
module abfe_back import abfe_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF,
  localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             empty,
  input  desc_t            head,
  output logic             pop,
  output logic [IDX_W-1:0] rd_idx,
  input  logic [31:0]      rd_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [15:0]      out_code,
  output logic             out_neg,
  output logic [7:0]       out_off,
  output logic [31:0]      out_mag,
  output logic             out_err,
  output logic             out_done
);

  localparam logic signed [10:0] R_LIMIT = 11'sd57;

  back_state_t state, state_next;
  logic [CNT_W-1:0] idx;
  logic slot_free;
  logic load_hdr;
  logic load_elem;
  logic last_elem;

  logic [4:0] ew;
  logic [3:0] ow;
  logic [5:0] mw;
  logic [7:0] maxoff;
  logic [31:0] maxmag;

  logic signed [16:0] shared17, lim, coded;
  logic hdr_err;
  logic [15:0] hdr_code;

  val_t v;
  logic signed [10:0] shared_x, off_raw, r_c;
  logic [7:0] off_c;
  mag_mode_t mode_c;
  logic [5:0] sh_c;
  logic neg_c;
  logic [55:0] prod_c;

  logic [55:0] m_prod;
  logic [5:0] m_sh;
  mag_mode_t m_mode;
  logic m_neg;
  logic [7:0] m_off;

  logic [56:0] shifted, rounded;
  logic [55:0] mag_full;
  logic [31:0] mag_c;

  // register clamps
  always_comb begin
    if (cfg.exponent_width < 5'd2) ew = 5'd2;
    else if (cfg.exponent_width > 5'd16) ew = 5'd16;
    else ew = cfg.exponent_width;
    if (cfg.offset_width == '0) ow = 4'd1;
    else if (cfg.offset_width > 4'd8) ow = 4'd8;
    else ow = cfg.offset_width;
    if (cfg.mantissa_width == '0) mw = 6'd1;
    else if (cfg.mantissa_width > 6'd32) mw = 6'd32;
    else mw = cfg.mantissa_width;
  end

  assign maxoff = 8'((9'd1 << ow) - 9'd1);
  assign maxmag = 32'((33'd1 << mw) - 33'd1);

  // header code with saturation
  always_comb begin
    shared17 = 17'(head.shared);
    lim = $signed(17'd1 << (ew - 5'd1));
    hdr_err = (shared17 > (lim - 17'sd1)) || (shared17 < -lim);
    if (shared17 > (lim - 17'sd1)) coded = lim - 17'sd1;
    else if (shared17 < -lim) coded = -lim;
    else coded = shared17;
    hdr_code = coded[15:0] & 16'((17'd1 << ew) - 17'd1);
  end

  // element decode and multiply
  assign v = split_value(rd_data);
  assign prod_c = 56'(v.sig) * 56'(maxmag);

  always_comb begin
    shared_x = 11'(head.shared);
    off_raw = shared_x - 11'(v.e);
    if (v.kind == VAL_ZERO) off_c = maxoff;
    else if (off_raw < 11'sd0) off_c = '0;
    else if (off_raw > $signed({3'b0, maxoff})) off_c = maxoff;
    else off_c = off_raw[7:0];
    r_c = shared_x - $signed({3'b0, off_c}) - 11'(v.q);
    sh_c = 6'(r_c - 11'sd1);
    neg_c = (v.kind != VAL_ZERO) && rd_data[31];
    case (v.kind)
      VAL_ZERO:    mode_c = MAG_ZERO;
      VAL_SPECIAL: mode_c = MAG_SAT;
      default: begin
        if (r_c <= 11'sd0) mode_c = MAG_SAT;
        else if (r_c > R_LIMIT) mode_c = MAG_ZERO;
        else mode_c = MAG_CALC;
      end
    endcase
  end

  // round half away from zero, then saturate
  always_comb begin
    shifted = {1'b0, m_prod} >> m_sh;
    rounded = shifted + 57'd1;
    mag_full = rounded[56:1];
    case (m_mode)
      MAG_ZERO: mag_c = '0;
      MAG_SAT:  mag_c = maxmag;
      default: begin
        if (mag_full > {24'b0, maxmag}) mag_c = maxmag;
        else mag_c = mag_full[31:0];
      end
    endcase
  end

  // control outputs
  always_comb begin
    slot_free = !out_valid || out_ready;
    load_hdr = (state == B_HEAD) && slot_free;
    load_elem = (state == B_EMIT) && slot_free;
    last_elem = (idx == (head.count - CNT_W'(1)));
    pop = load_elem && last_elem;
    rd_idx = (state == B_HEAD) ? '0 : IDX_W'(idx + CNT_W'(1));
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty) state_next = B_HEAD;
      end
      B_HEAD: begin
        if (slot_free) state_next = B_MUL;
      end
      B_MUL: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (slot_free) state_next = last_elem ? B_IDLE : B_MUL;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      if (load_hdr || load_elem) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load_hdr) idx <= '0;
      else if (load_elem) idx <= idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_MUL) begin
      m_prod <= prod_c;
      m_sh <= sh_c;
      m_mode <= mode_c;
      m_neg <= neg_c;
      m_off <= off_c;
    end
    if (load_hdr) begin
      out_kind <= KIND_HEADER;
      out_code <= hdr_code;
      out_neg <= 1'b0;
      out_off <= '0;
      out_mag <= '0;
      out_err <= hdr_err;
      out_done <= 1'b0;
    end else if (load_elem) begin
      out_kind <= KIND_ELEMENT;
      out_code <= '0;
      out_neg <= m_neg;
      out_off <= m_off;
      out_mag <= mag_c;
      out_err <= 1'b0;
      out_done <= last_elem;
    end
  end

endmodule

// ===== src/adaptive_block_float_encoder.sv =====
// top level of the block floating point encoder
// input: one value a cycle while fewer than two closed blocks wait in the value buffer
// output: a block of n values leaves as header plus n elements, one element at a time
//   through the shared decode, multiply and round unit (B_MUL, then B_EMIT)
// header: after the closing value is pushed, an idle back end goes from B_IDLE to B_HEAD and registers it
// rst: synchronous, clears control state and loads register defaults; buffer needs no clearing
`timescale 1ns / 1ps
`include "adaptive_block_float_encoder_macros.svh"
module adaptive_block_float_encoder import abfe_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value_bits
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // exponent_code, negative, exponent_offset, magnitude, range_error, zero fill
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // item_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  cfg_t cfg;
  logic q_full;
  logic q_empty;
  logic push;
  desc_t push_desc;
  logic pop;
  desc_t head;
  logic wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0] wr_data;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0] rd_data;
  logic [15:0] code;
  logic neg;
  logic [7:0] off;
  logic [31:0] mag;
  logic err;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_BLOCK_LENGTH:   cfg.block_length <= cfg_data;
        REG_EXPONENT_WIDTH: cfg.exponent_width <= cfg_data[4:0];
        REG_OFFSET_WIDTH:   cfg.offset_width <= cfg_data[3:0];
        REG_MANTISSA_WIDTH: cfg.mantissa_width <= cfg_data;
        default: ;
      endcase
    end
  end

  abfe_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_data      (s_axis_tdata),
    .in_last      (s_axis_tlast),
    .block_length (cfg.block_length),
    .q_full       (q_full),
    .push         (push),
    .push_desc    (push_desc),
    .wr_en        (wr_en),
    .wr_idx       (wr_idx),
    .wr_data      (wr_data)
  );

  abfe_queue #(.MAX_BLOCK(MAX_BLOCK)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data)
  );

  abfe_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_code  (code),
    .out_neg   (neg),
    .out_off   (off),
    .out_mag   (mag),
    .out_err   (err),
    .out_done  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, err, mag, off, neg, code};

  `ASSERT_ALWAYS(a_queue_count, clk, rst, !(q_full && q_empty))
  `ASSERT_NEXT(a_push_fills, clk, rst, push, !q_empty)
  `ASSERT_IMPLY(a_elem_no_err, clk, rst, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[57])
  `ASSERT_IMPLY(a_header_not_last, clk, rst, m_axis_tvalid && !m_axis_tuser, !m_axis_tlast)

endmodule
